@@ rtl/core/pbcs_pkg.sv @@
// Shared types and constants for the page bitmap command stream block.
// No dependencies; used by pbcs_step and page_bitmap_command_stream.
package pbcs_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BITMAP_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BITMAP_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COL_LOW_OP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COL_HIGH_OP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_OP      = 3'd6;

    localparam logic [7:0] LOW_NIBBLE_MASK  = 8'h0F;
    localparam logic [7:0] HIGH_NIBBLE_MASK = 8'hF0;

    // slot of the data byte in the pending result buffer
    localparam logic [1:0] SLOT_DATA     = 2'd3;
    localparam logic [1:0] SLOT_LAST_CMD = 2'd2;
    localparam logic [1:0] SLOT_FIRST    = 2'd0;

    typedef struct packed {
        logic signed [7:0] x_offset;
        logic signed [7:0] y_offset;
        logic [7:0]        bitmap_width;
        logic [7:0]        bitmap_height;
        logic [7:0]        column_low_opcode;
        logic [7:0]        column_high_opcode;
        logic [7:0]        page_opcode;
    } t_cfg;

    typedef struct packed {
        logic [7:0] column_index;
        logic [4:0] page_row_index;
        logic [3:0] next_page_address;
    } t_pos;

    typedef struct packed {
        logic            has_cmd;
        logic            has_data;
        logic [2:0][7:0] cmd_byte;
    } t_res;

endpackage

@@ rtl/core/page_bitmap_command_stream.sv @@
// Top level: config registers, bitmap position counters, result buffer.
// Depends on pbcs_pkg and pbcs_step.
//
// One bitmap byte is taken per transfer and decoded in the accept cycle into
// up to four results (three page-start command bytes, then the data byte),
// held in a four-slot buffer that feeds the output register one result per
// cycle while the output is not stalled. A new byte is taken once the last
// pending result moves out, so data bytes stream at one per cycle unstalled;
// a visible page-row start holds the input while its commands drain. Results
// pass through the pending buffer, then the output register. Write config
// only while no transfer is in flight.
module page_bitmap_command_stream #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pbcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_pixel_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_out_byte,
    output logic                           o_is_command,
    output logic                           o_last_of_run
);

    pbcs_pkg::t_cfg r_cfg;
    pbcs_pkg::t_pos r_pos;
    pbcs_pkg::t_pos n_pos;
    pbcs_pkg::t_res step_res;

    logic             r_pend_valid;
    logic [1:0]       r_pend_idx;
    logic [1:0]       r_pend_last_idx;
    logic [3:0][7:0]  r_pend_byte;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_cmd;
    logic             r_out_last;

    logic out_free;
    logic pend_last;
    logic in_take;

    pbcs_step #(
        .DISPLAY_WIDTH (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
    ) u_step (
        .i_cfg(r_cfg),
        .i_pos(r_pos),
        .o_pos(n_pos),
        .o_res(step_res)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign pend_last  = r_pend_idx == r_pend_last_idx;
    assign o_in_stall = r_pend_valid && !(pend_last && out_free);
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_is_command  = r_out_cmd;
    assign o_last_of_run = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_offset           <= 8'sd0;
            r_cfg.y_offset           <= 8'sd0;
            r_cfg.bitmap_width       <= 8'd128;
            r_cfg.bitmap_height      <= 8'd64;
            r_cfg.column_low_opcode  <= 8'h00;
            r_cfg.column_high_opcode <= 8'h10;
            r_cfg.page_opcode        <= 8'hB0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pbcs_pkg::REG_X_OFFSET:      r_cfg.x_offset           <= i_cfg_data;
                pbcs_pkg::REG_Y_OFFSET:      r_cfg.y_offset           <= i_cfg_data;
                pbcs_pkg::REG_BITMAP_WIDTH:  r_cfg.bitmap_width       <= i_cfg_data;
                pbcs_pkg::REG_BITMAP_HEIGHT: r_cfg.bitmap_height      <= i_cfg_data;
                pbcs_pkg::REG_COL_LOW_OP:    r_cfg.column_low_opcode  <= i_cfg_data;
                pbcs_pkg::REG_COL_HIGH_OP:   r_cfg.column_high_opcode <= i_cfg_data;
                pbcs_pkg::REG_PAGE_OP:       r_cfg.page_opcode        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (in_take) begin
            r_pos <= n_pos;
        end
    end

    // pending results: command slots 0..2, data slot 3
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid    <= 1'b0;
            r_pend_idx      <= pbcs_pkg::SLOT_FIRST;
            r_pend_last_idx <= pbcs_pkg::SLOT_DATA;
        end else begin
            if (r_pend_valid && out_free) begin
                if (pend_last) begin
                    r_pend_valid <= 1'b0;
                end else begin
                    r_pend_idx <= r_pend_idx + 2'd1;
                end
            end
            if (in_take && (step_res.has_cmd || step_res.has_data)) begin
                r_pend_valid    <= 1'b1;
                r_pend_idx      <= step_res.has_cmd ? pbcs_pkg::SLOT_FIRST
                                                    : pbcs_pkg::SLOT_DATA;
                r_pend_last_idx <= step_res.has_data ? pbcs_pkg::SLOT_DATA
                                                     : pbcs_pkg::SLOT_LAST_CMD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_pend_byte[0] <= step_res.cmd_byte[0];
            r_pend_byte[1] <= step_res.cmd_byte[1];
            r_pend_byte[2] <= step_res.cmd_byte[2];
            r_pend_byte[3] <= i_pixel_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_pend_valid) begin
            r_out_byte <= r_pend_byte[r_pend_idx];
            r_out_cmd  <= r_pend_idx != pbcs_pkg::SLOT_DATA;
            r_out_last <= pend_last;
        end
    end

`ifndef ASSERT_OFF
    a_pend_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_pend_idx <= r_pend_last_idx)
        else $error("pending slot index past last slot");

    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && !r_out_valid) |=> r_out_valid)
        else $error("free output register did not take pending result");

    a_no_early_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && !pend_last) |-> o_in_stall)
        else $error("input transfer while several results pending");
`endif

endmodule

@@ rtl/core/pbcs_step.sv @@
// Per-byte decode: visibility, command bytes and next counter values.
// Depends on pbcs_pkg.
module pbcs_step #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
) (
    input  pbcs_pkg::t_cfg i_cfg,
    input  pbcs_pkg::t_pos i_pos,
    output pbcs_pkg::t_pos o_pos,
    output pbcs_pkg::t_res o_res
);

    localparam logic [9:0] DISP_W = 10'(DISPLAY_WIDTH);
    localparam logic [9:0] DISP_H = 10'(DISPLAY_HEIGHT);

    logic [8:0] height_sum;
    logic [5:0] rows;
    logic       active;
    logic       first_byte;
    logic [3:0] page_base;
    logic [3:0] page_cur;
    logic [9:0] top_line;
    logic [9:0] screen_col;
    logic       row_visible;
    logic       col_visible;
    logic [7:0] col_start;
    logic [8:0] col_inc;
    logic [5:0] row_inc;
    logic       emit_cmd;

    always_comb begin
        height_sum  = {1'b0, i_cfg.bitmap_height} + 9'd7;
        rows        = 6'(height_sum >> 3);
        active      = (i_cfg.bitmap_width != 8'd0) && (rows != 6'd0);
        first_byte  = (i_pos.column_index == 8'd0) && (i_pos.page_row_index == 5'd0);
        page_base   = i_cfg.y_offset[7] ? 4'd0 : i_cfg.y_offset[6:3];
        page_cur    = first_byte ? page_base : i_pos.next_page_address;

        top_line    = {{2{i_cfg.y_offset[7]}}, i_cfg.y_offset}
                      + {2'b00, i_pos.page_row_index, 3'b000};
        row_visible = !top_line[9] && (top_line < DISP_H);
        screen_col  = {{2{i_cfg.x_offset[7]}}, i_cfg.x_offset}
                      + {2'b00, i_pos.column_index};
        col_visible = !screen_col[9] && (screen_col < DISP_W);

        col_start   = i_cfg.x_offset[7] ? 8'd0 : i_cfg.x_offset;
        emit_cmd    = active && row_visible && (i_pos.column_index == 8'd0);

        o_res.has_cmd     = emit_cmd;
        o_res.has_data    = active && row_visible && col_visible;
        o_res.cmd_byte[0] = i_cfg.column_low_opcode
                            | (col_start & pbcs_pkg::LOW_NIBBLE_MASK);
        o_res.cmd_byte[1] = i_cfg.column_high_opcode
                            | ((col_start & pbcs_pkg::HIGH_NIBBLE_MASK) >> 4);
        o_res.cmd_byte[2] = i_cfg.page_opcode | {4'b0000, page_cur};

        col_inc = {1'b0, i_pos.column_index} + 9'd1;
        row_inc = {1'b0, i_pos.page_row_index} + 6'd1;

        o_pos = i_pos;
        if (active) begin
            o_pos.next_page_address = emit_cmd ? page_cur + 4'd1 : page_cur;
            if (col_inc >= {1'b0, i_cfg.bitmap_width}) begin
                o_pos.column_index = 8'd0;
                if (row_inc >= rows) begin
                    o_pos.page_row_index = 5'd0;
                end else begin
                    o_pos.page_row_index = row_inc[4:0];
                end
            end else begin
                o_pos.column_index = col_inc[7:0];
            end
        end
    end

endmodule
